/* hdl/ssad_pkg.sv */
// ssad_pkg: shared types, constants and functions for the autorange display.
// No dependencies; used by every module of the block.
package ssad_pkg;

    localparam int FRAC_BITS   = 10;
    localparam int VALUE_W     = 16 + FRAC_BITS;
    localparam int SCALE_W     = 10;
    localparam int SCALED_W    = 16;
    localparam int DIGITS      = 4;
    localparam int ITEM_CYCLES = DIGITS;

    localparam logic [VALUE_W-1:0] LIM_TEN      = VALUE_W'(10 << FRAC_BITS);
    localparam logic [VALUE_W-1:0] LIM_HUNDRED  = VALUE_W'(100 << FRAC_BITS);
    localparam logic [VALUE_W-1:0] LIM_THOUSAND = VALUE_W'(1000 << FRAC_BITS);

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for every 16-bit x
    localparam logic [SCALED_W-1:0] DIV10_MUL   = 16'hCCCD;
    localparam int                  DIV10_SHIFT = 19;

    localparam logic [7:0] DP_BIT = 8'b1000_0000;

    typedef enum logic [1:0] {
        PT_NONE     = 2'd0,
        PT_TENS     = 2'd1,
        PT_HUNDREDS = 2'd2,
        PT_THOUSAND = 2'd3
    } point_t;

    typedef struct packed {
        logic                     valid;
        point_t                   point;
        logic [SCALED_W-1:0]      rem;
        logic [DIGITS-1:0][3:0]   digits;
    } stage_t;

    function automatic logic [SCALE_W-1:0] scale_of(input point_t pt);
        logic [SCALE_W-1:0] s;
        unique case (pt)
            PT_THOUSAND: s = SCALE_W'(1000);
            PT_HUNDREDS: s = SCALE_W'(100);
            PT_TENS:     s = SCALE_W'(10);
            default:     s = SCALE_W'(1);
        endcase
        return s;
    endfunction

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h67;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

/* hdl/ssad_scale.sv */
// ssad_scale: range pick on the input, then scale and truncate (two stages).
// Depends on ssad_pkg.
module ssad_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [ssad_pkg::VALUE_W-1:0]  value,
    output ssad_pkg::stage_t              stage_out
);

    logic                                   valid1_reg;
    logic [ssad_pkg::VALUE_W-1:0]           v_reg;
    ssad_pkg::point_t                       point_reg;
    ssad_pkg::point_t                       point_next;

    logic                                   valid2_reg;
    logic [ssad_pkg::SCALED_W-1:0]          scaled_reg;
    ssad_pkg::point_t                       point2_reg;

    logic [ssad_pkg::VALUE_W+ssad_pkg::SCALE_W-1:0] product;

    always_comb
    begin
        if (value < ssad_pkg::LIM_TEN)
        begin
            point_next = ssad_pkg::PT_THOUSAND;
        end
        else if (value < ssad_pkg::LIM_HUNDRED)
        begin
            point_next = ssad_pkg::PT_HUNDREDS;
        end
        else if (value < ssad_pkg::LIM_THOUSAND)
        begin
            point_next = ssad_pkg::PT_TENS;
        end
        else
        begin
            point_next = ssad_pkg::PT_NONE;
        end
    end

    assign product = (ssad_pkg::VALUE_W + ssad_pkg::SCALE_W)'(v_reg)
                   * (ssad_pkg::VALUE_W + ssad_pkg::SCALE_W)'(ssad_pkg::scale_of(point_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= accept;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg     <= value;
            point_reg <= point_next;
        end
        // scaled value stays below 2^16 in every range
        scaled_reg <= product[ssad_pkg::FRAC_BITS +: ssad_pkg::SCALED_W];
        point2_reg <= point_reg;
    end

    always_comb
    begin
        stage_out.valid  = valid2_reg;
        stage_out.point  = point2_reg;
        stage_out.rem    = scaled_reg;
        stage_out.digits = '0;
    end

endmodule

/* hdl/ssad_digit.sv */
// ssad_digit: one decimal digit peeled per stage by reciprocal multiply.
// Depends on ssad_pkg.
module ssad_digit (
    input  logic              clk,
    input  logic              rst_n,
    input  ssad_pkg::stage_t  stage_in,
    output ssad_pkg::stage_t  stage_out
);

    localparam int PROD_W = 2 * ssad_pkg::SCALED_W;
    localparam int Q_W    = PROD_W - ssad_pkg::DIV10_SHIFT;

    logic [PROD_W-1:0]                  prod;
    logic [Q_W-1:0]                     quot;
    logic [ssad_pkg::SCALED_W-1:0]      ten_q;
    logic [ssad_pkg::SCALED_W-1:0]      diff;

    logic                                           valid_reg;
    ssad_pkg::point_t                               point_reg;
    logic [ssad_pkg::SCALED_W-1:0]                  rem_reg;
    logic [ssad_pkg::DIGITS-1:0][3:0]               digits_reg;

    assign prod  = PROD_W'(stage_in.rem) * PROD_W'(ssad_pkg::DIV10_MUL);
    assign quot  = prod[PROD_W-1:ssad_pkg::DIV10_SHIFT];
    assign ten_q = ssad_pkg::SCALED_W'({quot, 3'b000}) + ssad_pkg::SCALED_W'({quot, 1'b0});
    assign diff  = stage_in.rem - ten_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    // digits shift down; after four stages the least significant sits at [0]
    always_ff @(posedge clk)
    begin
        point_reg  <= stage_in.point;
        rem_reg    <= ssad_pkg::SCALED_W'(quot);
        digits_reg <= {diff[3:0], stage_in.digits[ssad_pkg::DIGITS-1:1]};
    end

    always_comb
    begin
        stage_out.valid  = valid_reg;
        stage_out.point  = point_reg;
        stage_out.rem    = rem_reg;
        stage_out.digits = digits_reg;
    end

endmodule

/* hdl/ssad_serial.sv */
// ssad_serial: emits the four digits of a transaction, one per cycle, on
// registered outputs. Depends on ssad_pkg.
module ssad_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  ssad_pkg::stage_t  stage_in,
    output logic              strobe,
    output logic [1:0]        digit_index,
    output logic [3:0]        digit_select,
    output logic [7:0]        segments,
    output logic              last
);

    logic                               active_reg;
    logic                               active_next;
    logic [1:0]                         idx_reg;
    logic [1:0]                         idx_next;
    logic [ssad_pkg::DIGITS-1:0][3:0]   hold_reg;
    ssad_pkg::point_t                   hold_point_reg;

    logic                               emit;
    logic [1:0]                         emit_idx;
    logic [3:0]                         emit_digit;
    ssad_pkg::point_t                   emit_point;

    logic                               strobe_reg;
    logic [1:0]                         index_reg;
    logic [3:0]                         select_reg;
    logic [7:0]                         seg_reg;
    logic                               last_reg;
    logic [7:0]                         seg_next;

    always_comb
    begin
        emit        = 1'b0;
        emit_idx    = idx_reg;
        emit_digit  = hold_reg[idx_reg];
        emit_point  = hold_point_reg;
        active_next = active_reg;
        idx_next    = idx_reg;
        if (stage_in.valid)
        begin
            emit        = 1'b1;
            emit_idx    = 2'd0;
            emit_digit  = stage_in.digits[0];
            emit_point  = stage_in.point;
            active_next = 1'b1;
            idx_next    = 2'd1;
        end
        else if (active_reg)
        begin
            emit     = 1'b1;
            idx_next = idx_reg + 2'd1;
            if (idx_reg == 2'(ssad_pkg::DIGITS - 1))
            begin
                active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        seg_next = ssad_pkg::seg_code(emit_digit);
        if (emit_point != ssad_pkg::PT_NONE && emit_idx == 2'(emit_point))
        begin
            seg_next = seg_next | ssad_pkg::DP_BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 2'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_in.valid)
        begin
            hold_reg       <= stage_in.digits;
            hold_point_reg <= stage_in.point;
        end
        index_reg  <= emit_idx;
        select_reg <= ~(4'b1000 >> emit_idx);
        seg_reg    <= seg_next;
        last_reg   <= (emit_idx == 2'(ssad_pkg::DIGITS - 1));
    end

    assign strobe       = strobe_reg;
    assign digit_index  = index_reg;
    assign digit_select = select_reg;
    assign segments     = seg_reg;
    assign last         = last_reg;

    // a new transaction must never land on a run still in progress
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        stage_in.valid |-> !active_reg)
        else $error("digit run overrun");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !last_reg) |=> (strobe_reg && index_reg == $past(index_reg) + 2'd1))
        else $error("digit run broken");

    a_one_select: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $onehot(~select_reg))
        else $error("digit select not one-cold");

endmodule

/* hdl/seven_segment_autorange_display.sv */
// seven_segment_autorange_display: top level, autoranging four-digit display
// driver. Depends on ssad_pkg, ssad_scale, ssad_digit, ssad_serial.
//
// Usage:
//   Input: drive value (unsigned Q16.10) and raise start; the transaction is
//   taken at a rising edge where start is high and busy is low.
//   Output: four results follow, least significant digit first, each shown
//   for exactly one cycle with strobe high: digit_index, active-low
//   digit_select, segments (a..g in bits 0..6, point in bit 7) and last on
//   the fourth digit.
//   The first digit passes the range pick, the scale multiply, four
//   divide-by-ten stages and the output register, in that order; the other
//   three follow in consecutive cycles. Transactions are paced by the
//   single result port that emits one digit per cycle: busy goes high after
//   each accept and blocks start until the port can take the next run, and
//   the next transaction may enter while earlier ones are still in the
//   pipeline.
//   Reset: rst_n clears all valid bits and the run counter; no strobe until
//   a transaction is accepted.
//   The receiver cannot stall: every result is presented once and is gone
//   in the next cycle.
module seven_segment_autorange_display (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ssad_pkg::VALUE_W-1:0]  value,
    output logic                          strobe,
    output logic [1:0]                    digit_index,
    output logic [3:0]                    digit_select,
    output logic [7:0]                    segments,
    output logic                          last
);

    logic [1:0]         cool_reg;
    logic [1:0]         cool_next;
    logic               accept;

    ssad_pkg::stage_t   stage [ssad_pkg::DIGITS+1];

    assign accept = start && !busy;
    assign busy   = (cool_reg != 2'd0);

    always_comb
    begin
        cool_next = cool_reg;
        if (accept)
        begin
            cool_next = 2'(ssad_pkg::ITEM_CYCLES - 1);
        end
        else if (cool_reg != 2'd0)
        begin
            cool_next = cool_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cool_reg <= 2'd0;
        end
        else
        begin
            cool_reg <= cool_next;
        end
    end

    ssad_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .value     (value),
        .stage_out (stage[0])
    );

    for (genvar g = 0; g < ssad_pkg::DIGITS; g++)
    begin : g_digit
        ssad_digit u_digit (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage[g]),
            .stage_out (stage[g+1])
        );
    end

    ssad_serial u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage_in     (stage[ssad_pkg::DIGITS]),
        .strobe       (strobe),
        .digit_index  (digit_index),
        .digit_select (digit_select),
        .segments     (segments),
        .last         (last)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy ##1 busy ##1 busy ##1 !busy)
        else $error("busy window wrong after transaction");

endmodule
